FILE: design/hhfx_pkg.sv
// Shared constants and request/result types of the HTTP header field extractor.
`default_nettype none
package hhfx_pkg;

  localparam int LINE_BUF    = 4096;
  localparam int NUM_KEYS    = 4;
  localparam int MAX_KEY_LEN = 32;

  localparam int LC_W       = 13;
  localparam int KEY_SLOT_W = 2;
  localparam int KEY_POS_W  = 5;
  localparam int KEY_LEN_W  = 6;
  localparam int LIMIT_W    = 3;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [1:0] CMD_HDR_BYTE = 2'd0;
  localparam logic [1:0] CMD_KEY_CHAR = 2'd1;
  localparam logic [1:0] CMD_KEY_LEN  = 2'd2;
  localparam logic [1:0] CMD_START    = 2'd3;

  localparam logic [2:0] KIND_VALUE_BYTE    = 3'd0;
  localparam logic [2:0] KIND_VALUE_RESTART = 3'd1;
  localparam logic [2:0] KIND_VALUE_DONE    = 3'd2;
  localparam logic [2:0] KIND_STATUS_BYTE   = 3'd3;
  localparam logic [2:0] KIND_STATUS_DONE   = 3'd4;
  localparam logic [2:0] KIND_HEADER_END    = 3'd5;

  localparam logic [1:0] REG_KEYS_IN_USE = 2'd0;
  localparam logic [1:0] REG_KEEP_STATUS = 2'd1;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [7:0]            byte_value;
    logic [KEY_SLOT_W-1:0] key_slot;
    logic [KEY_POS_W-1:0]  key_pos;
    logic [KEY_LEN_W-1:0]  key_len;
  } item_t;

  typedef struct packed {
    logic [2:0]            kind;
    logic [7:0]            data_byte;
    logic [KEY_SLOT_W-1:0] matched_key;
    logic [LC_W-1:0]       length;
  } result_t;

endpackage
`default_nettype wire

FILE: design/http_header_field_extractor_top.sv
// Top level of the HTTP header field extractor: key lanes, line state and result buffer.
//
//  channel  | signals                           | direction | payload
//  ---------+-----------------------------------+-----------+------------------
//  request  | hdr_valid, hdr_stall, hdr_item    | in        | hhfx_pkg::item_t
//  result   | res_valid, res_stall, res_item    | out       | hhfx_pkg::result_t
//  config   | cfg_valid, cfg_ready, cfg_index,  | in        | 3-bit register data
//           | cfg_data                          |           |
//
//  One request is taken every cycle while hdr_stall is low; its result, if any,
//  is registered into a two-entry result buffer that lets requests continue
//  while one result is stalled; hdr_stall rises only when both entries are full.
//  Key characters sit in one 32-entry bank per lane, read through a register at the
//  next line position. rst clears all control state; key characters are
//  undefined until written, so no clearing pass follows reset.
`default_nettype none
module http_header_field_extractor_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               hdr_valid,
  output logic                    hdr_stall,
  input  wire hhfx_pkg::item_t    hdr_item,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output hhfx_pkg::result_t       res_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [2:0]         cfg_data
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_STATUS = 2'd1;
  localparam logic [1:0] PH_FIELDS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam int NK  = hhfx_pkg::NUM_KEYS;
  localparam int LCW = hhfx_pkg::LC_W;
  localparam int KLW = hhfx_pkg::KEY_LEN_W;
  localparam int KSW = hhfx_pkg::KEY_SLOT_W;
  localparam int KPW = hhfx_pkg::KEY_POS_W;

  logic [hhfx_pkg::LIMIT_W-1:0] keys_in_use;
  logic                         keep_status;

  logic [1:0]      phase, phase_next;
  logic [LCW-1:0]  line_count, line_count_next;
  logic [7:0]      last_stored, last_stored_next;
  logic [KSW-1:0]  selected_key, selected_key_next;
  logic            key_sel, key_sel_next;
  logic [NK-1:0]   alive, alive_next;
  logic [NK-1:0]   alive_before, alive_before_next;
  logic [KLW-1:0]  key_len [NK];
  logic [KLW-1:0]  key_len_next [NK];

  logic [NK-1:0]   lane_ok;
  logic            match_any;
  logic [KSW-1:0]  match_idx;
  logic [hhfx_pkg::LIMIT_W-1:0] limit;
  logic [LCW-1:0]  want;
  logic [KLW-1:0]  len_sat;

  logic              acc;
  logic              key_we;
  logic              push;
  logic              pop;
  hhfx_pkg::result_t res_new;
  hhfx_pkg::result_t head, tail;
  logic [1:0]        cnt, cnt_next;

  assign acc       = hdr_valid && !hdr_stall;
  assign key_we    = acc && (hdr_item.cmd == hhfx_pkg::CMD_KEY_CHAR);
  assign cfg_ready = 1'b1;
  assign hdr_stall = (cnt == 2'd2);
  assign res_valid = (cnt != 2'd0);
  assign res_item  = head;
  assign pop       = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_in_use <= '0;
      keep_status <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hhfx_pkg::REG_KEYS_IN_USE: keys_in_use <= cfg_data;
        hhfx_pkg::REG_KEEP_STATUS: keep_status <= cfg_data[0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NK; g++) begin : g_lane
    logic [7:0] lane_mem [hhfx_pkg::MAX_KEY_LEN];
    logic [7:0] lane_rd;

    always_ff @(posedge clk) begin
      if (key_we && (hdr_item.key_slot == KSW'(g))) begin
        lane_mem[hdr_item.key_pos] <= hdr_item.byte_value;
      end
      if (key_we && (hdr_item.key_slot == KSW'(g)) &&
          (hdr_item.key_pos == line_count_next[KPW-1:0])) begin
        lane_rd <= hdr_item.byte_value;
      end else begin
        lane_rd <= lane_mem[line_count_next[KPW-1:0]];
      end
    end

    assign lane_ok[g] = (line_count < LCW'(key_len[g])) &&
                        (line_count < LCW'(hhfx_pkg::MAX_KEY_LEN)) &&
                        (lane_rd == hdr_item.byte_value);
  end

  assign limit   = (keys_in_use > hhfx_pkg::LIMIT_W'(NK)) ?
                   hhfx_pkg::LIMIT_W'(NK) : keys_in_use;
  assign want    = line_count - LCW'(1);
  assign len_sat = (hdr_item.key_len > KLW'(hhfx_pkg::MAX_KEY_LEN)) ?
                   KLW'(hhfx_pkg::MAX_KEY_LEN) : hdr_item.key_len;

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int k = NK - 1; k >= 0; k--) begin
      if ((hhfx_pkg::LIMIT_W'(k) < limit) && alive_before[k] &&
          (LCW'(key_len[k]) == want)) begin
        match_any = 1'b1;
        match_idx = KSW'(k);
      end
    end
  end

  always_comb begin
    phase_next        = phase;
    line_count_next   = line_count;
    last_stored_next  = last_stored;
    selected_key_next = selected_key;
    key_sel_next      = key_sel;
    alive_next        = alive;
    alive_before_next = alive_before;
    for (int k = 0; k < NK; k++) begin
      key_len_next[k] = key_len[k];
    end
    push    = 1'b0;
    res_new = '0;
    if (acc) begin
      case (hdr_item.cmd)
        hhfx_pkg::CMD_KEY_LEN: begin
          key_len_next[hdr_item.key_slot] = len_sat;
        end
        hhfx_pkg::CMD_START: begin
          phase_next        = PH_STATUS;
          selected_key_next = '0;
          key_sel_next      = 1'b0;
          line_count_next   = '0;
          last_stored_next  = '0;
          alive_next        = '1;
          alive_before_next = '1;
        end
        hhfx_pkg::CMD_HDR_BYTE: begin
          if (phase == PH_STATUS) begin
            if (hdr_item.byte_value == hhfx_pkg::CH_LF) begin
              phase_next        = PH_FIELDS;
              line_count_next   = '0;
              last_stored_next  = '0;
              alive_next        = '1;
              alive_before_next = '1;
              push              = keep_status;
              res_new.kind      = hhfx_pkg::KIND_STATUS_DONE;
              res_new.length    = line_count;
            end else if (line_count < LCW'(hhfx_pkg::LINE_BUF)) begin
              alive_before_next = alive;
              alive_next        = alive & lane_ok;
              last_stored_next  = hdr_item.byte_value;
              line_count_next   = line_count + LCW'(1);
              push              = keep_status;
              res_new.kind      = hhfx_pkg::KIND_STATUS_BYTE;
              res_new.data_byte = hdr_item.byte_value;
            end
          end else if (phase == PH_FIELDS) begin
            if (hdr_item.byte_value == hhfx_pkg::CH_CR) begin
              push = 1'b0;
            end else if (hdr_item.byte_value == hhfx_pkg::CH_LF) begin
              if (line_count == '0) begin
                phase_next   = PH_DONE;
                push         = 1'b1;
                res_new.kind = hhfx_pkg::KIND_HEADER_END;
              end else begin
                key_sel_next        = 1'b0;
                selected_key_next   = '0;
                line_count_next     = '0;
                last_stored_next    = '0;
                alive_next          = '1;
                alive_before_next   = '1;
                push                = key_sel;
                res_new.kind        = hhfx_pkg::KIND_VALUE_DONE;
                res_new.matched_key = selected_key;
                res_new.length      = line_count;
              end
            end else if ((hdr_item.byte_value == hhfx_pkg::CH_SP) &&
                         (line_count != '0) &&
                         (last_stored == hhfx_pkg::CH_COLON)) begin
              if (match_any) begin
                selected_key_next = match_idx;
                key_sel_next      = 1'b1;
              end
              line_count_next     = '0;
              last_stored_next    = '0;
              alive_next          = '1;
              alive_before_next   = '1;
              push                = key_sel;
              res_new.kind        = hhfx_pkg::KIND_VALUE_RESTART;
              res_new.matched_key = selected_key;
              res_new.length      = line_count;
            end else if (line_count < LCW'(hhfx_pkg::LINE_BUF)) begin
              alive_before_next   = alive;
              alive_next          = alive & lane_ok;
              last_stored_next    = hdr_item.byte_value;
              line_count_next     = line_count + LCW'(1);
              push                = key_sel;
              res_new.kind        = hhfx_pkg::KIND_VALUE_BYTE;
              res_new.data_byte   = hdr_item.byte_value;
              res_new.matched_key = selected_key;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      line_count   <= '0;
      last_stored  <= '0;
      selected_key <= '0;
      key_sel      <= 1'b0;
      alive        <= '1;
      alive_before <= '1;
      for (int k = 0; k < NK; k++) begin
        key_len[k] <= '0;
      end
    end else begin
      phase        <= phase_next;
      line_count   <= line_count_next;
      last_stored  <= last_stored_next;
      selected_key <= selected_key_next;
      key_sel      <= key_sel_next;
      alive        <= alive_next;
      alive_before <= alive_before_next;
      for (int k = 0; k < NK; k++) begin
        key_len[k] <= key_len_next[k];
      end
    end
  end

  assign cnt_next = cnt + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (cnt == 2'd2)) begin
      head <= tail;
    end else if (push && ((cnt == 2'd0) || ((cnt == 2'd1) && pop))) begin
      head <= res_new;
    end
    if (push && (cnt == 2'd1) && !pop) begin
      tail <= res_new;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (cnt != 2'd2))
    else $error("result pushed into a full buffer");

  a_idle_bytes_silent: assert property (@(posedge clk) disable iff (rst)
    (acc && (hdr_item.cmd == hhfx_pkg::CMD_HDR_BYTE) &&
     ((phase == PH_IDLE) || (phase == PH_DONE))) |-> !push)
    else $error("header byte outside a header produced a result");

  a_status_lf: assert property (@(posedge clk) disable iff (rst)
    (acc && (hdr_item.cmd == hhfx_pkg::CMD_HDR_BYTE) && (phase == PH_STATUS) &&
     (hdr_item.byte_value == hhfx_pkg::CH_LF)) |=>
    ((phase == PH_FIELDS) && (line_count == '0)))
    else $error("status line end did not enter field lines");

  a_value_needs_key: assert property (@(posedge clk) disable iff (rst)
    (push && (res_new.kind == hhfx_pkg::KIND_VALUE_BYTE)) |-> key_sel)
    else $error("value byte without a selected key");
`endif

endmodule
`default_nettype wire
